FILE: rtl/core/rgbl_pkg.sv
package rgbl_pkg;

  localparam int LIN_W    = 17;
  localparam int Q24_W    = 25;
  localparam int LOWRES_W = 20;
  localparam logic [Q24_W-1:0] Q24_ONE = Q24_W'(1) << 24;

  // fifth-power search in Q0.24, shift of 24 after each product
  typedef logic [LIN_W-1:0] lin_tab_t [256];

  typedef struct packed {
    logic                vld;
    logic [Q24_W-1:0]    target;
    logic [Q24_W-1:0]    root;
    logic                islow;
    logic [LOWRES_W-1:0] lowres;
  } rgbl_tok_t;

  function automatic longint unsigned pow5_q24(longint unsigned r);
    longint unsigned r2;
    longint unsigned r4;
    r2 = (r * r) >> 24;
    r4 = (r2 * r2) >> 24;
    return (r4 * r) >> 24;
  endfunction

  function automatic longint unsigned linearize(longint unsigned c);
    longint unsigned num;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    longint unsigned cand;
    longint unsigned lin24;
    if (c <= 10) begin
      return (c * 64'd6553600 + 64'd164730) / 64'd329460;
    end
    num = 64'd1000 * c + 64'd14025;
    t = ((num << 25) + 64'd269025) / 64'd538050;
    s = (t * t + (64'd1 << 23)) >> 24;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand <= (64'd1 << 24)) begin
        if (pow5_q24(cand) <= s) begin
          r = cand;
        end
      end
    end
    lin24 = (s * r + (64'd1 << 23)) >> 24;
    return (lin24 + 64'd128) >> 8;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = LIN_W'(linearize(64'(i)));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

FILE: rtl/core/rgbl_cell.sv
module rgbl_cell #(
  parameter int BIT = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rgbl_pkg::rgbl_tok_t tok_in,
  output rgbl_pkg::rgbl_tok_t tok_out
);
  import rgbl_pkg::*;

  rgbl_tok_t        tok_a;
  rgbl_tok_t        tok_next;
  logic [Q24_W-1:0] cand;
  logic             skip;
  logic [Q24_W-1:0] sq;
  logic [Q24_W-1:0] cand_next;
  logic [2*Q24_W-1:0] sq_full;
  logic [2*Q24_W-1:0] cube_full;

  assign cand_next = tok_in.root | (Q24_W'(1) << BIT);
  assign sq_full   = cand_next * cand_next;
  assign cube_full = sq * cand;

  always_comb begin
    tok_next = tok_a;
    if (!skip && (cube_full[24 +: Q24_W] <= tok_a.target)) begin
      tok_next.root = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a.vld   <= 1'b0;
      tok_out.vld <= 1'b0;
    end else if (en) begin
      tok_a <= tok_in;
      cand  <= cand_next;
      skip  <= cand_next > Q24_ONE;
      sq    <= sq_full[24 +: Q24_W];
      tok_out <= tok_next;
    end
  end

endmodule

FILE: rtl/core/rgb_to_perceived_lightness.sv
// CIE L* lightness of one 8-bit sRGB pixel per item, as unsigned fixed point
// with OUT_FRAC_BITS fraction bits (0 to 100). Fully pipelined: one item is
// accepted every clock while pixel_ready is high. Five stages of
// linearisation, luminance and low-range scaling feed the cube-root chain of
// 25 cells (two register stages each, one per result bit), followed by the
// output register. pixel_ready drops only while the output register holds an
// item not yet taken.
module rgb_to_perceived_lightness #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  output logic                     pixel_ready,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [6+OUT_FRAC_BITS:0] lightness
);
  import rgbl_pkg::*;

  localparam int OW = 7 + OUT_FRAC_BITS;
  localparam logic [26:0] RECIP_625 = 27'd109951163;
  localparam logic [19:0] RECIP_5   = 20'd838861;
  localparam logic [16:0] LOW_Y_MAX = 17'(216 * 65536 / 24389);
  localparam logic [31:0] MAXV      = 32'(100) << OUT_FRAC_BITS;
  localparam logic [32:0] HALF      = 33'(1) << (23 - OUT_FRAC_BITS);

  logic en;
  assign en = !result_valid || result_ready;
  assign pixel_ready = en;

  logic              v1, v2, v3, v4, v5;
  logic [LIN_W-1:0]  rl, gl, bl;
  logic [25:0]       a10k;
  logic [16:0]       y3, y4, y5;
  logic [21:0]       alow;
  logic              islow4, islow5;
  logic [LOWRES_W-1:0] lowres5;

  logic [29:0] wsum;
  logic [52:0] yprod;
  logic [47:0] lowscaled;
  logic [41:0] lowprod;

  assign wsum = 30'(rl) * 30'd2126 + 30'(gl) * 30'd7152 + 30'(bl) * 30'd722 + 30'd5000;
  assign yprod = 53'(a10k) * 53'(RECIP_625);
  assign lowscaled = ((48'(y3) * 48'd9033) << OUT_FRAC_BITS) + 48'd327680;
  assign lowprod = 42'(alow) * 42'(RECIP_5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= pixel_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      rl <= LIN_TAB[red];
      gl <= LIN_TAB[green];
      bl <= LIN_TAB[blue];
      a10k <= wsum[29:4];
      y3 <= yprod[52:36];
      y4 <= y3;
      alow <= lowscaled[38:17];
      islow4 <= y3 <= LOW_Y_MAX;
      y5 <= y4;
      islow5 <= islow4;
      lowres5 <= lowprod[41:22];
    end
  end

  rgbl_tok_t chain [26];

  always_comb begin
    chain[0].vld    = v5;
    chain[0].target = {y5, 8'd0};
    chain[0].root   = '0;
    chain[0].islow  = islow5;
    chain[0].lowres = lowres5;
  end

  for (genvar i = 0; i < 25; i++) begin : g_cell
    rgbl_cell #(.BIT(24 - i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  rgbl_tok_t   last;
  logic signed [32:0] v;
  logic [32:0] rounded;
  logic [31:0] res;

  assign last = chain[25];
  assign v = $signed(33'(last.root) * 33'd116) - $signed(33'(1) << 28);
  assign rounded = (33'(v) + HALF) >> (24 - OUT_FRAC_BITS);

  always_comb begin
    if (last.islow) begin
      res = 32'(last.lowres);
    end else if (v <= 0) begin
      res = '0;
    end else begin
      res = rounded[31:0];
    end
    if (res > MAXV) begin
      res = MAXV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.vld;
      lightness <= res[OW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_ready : assert property (@(posedge clk) disable iff (rst)
    pixel_ready == (!result_valid || result_ready))
    else $error("ready mismatch");
  a_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(lightness) <= MAXV))
    else $error("lightness out of range");
  a_enter : assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready) |=> v1)
    else $error("item lost at entry");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(lightness)))
    else $error("result dropped while stalled");
`endif

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int LW = 7 + FRAC;
  localparam int N_RANDOM = 1030;
  localparam int LIMIT = 400000;
  localparam int TAIL = 80;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit known;
    logic [LW-1:0] l;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [LW-1:0] lightness;

  logic [LW-1:0] lstar_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_low = 0;
  int n_sat = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  pixel_row_t rows[$];

  rgb_to_perceived_lightness #(.OUT_FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue), .result_valid(result_valid),
    .result_ready(result_ready), .lightness(lightness)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned cube_q24(longint unsigned x);
    longint unsigned x2;
    x2 = (x * x) >> 24;
    return (x2 * x) >> 24;
  endfunction

  function automatic longint unsigned fifth_q24(longint unsigned x);
    longint unsigned x2;
    longint unsigned x4;
    x2 = (x * x) >> 24;
    x4 = (x2 * x2) >> 24;
    return (x4 * x) >> 24;
  endfunction

  function automatic longint unsigned root_search(longint unsigned goal, bit fifth);
    longint unsigned acc;
    longint unsigned trial;
    longint unsigned p;
    acc = 0;
    for (int k = 24; k >= 0; k--) begin
      trial = acc | (64'd1 << k);
      if (trial <= (64'd1 << 24)) begin
        p = fifth ? fifth_q24(trial) : cube_q24(trial);
        if (p <= goal) acc = trial;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned srgb_to_linear(logic [7:0] code);
    longint unsigned c;
    longint unsigned t;
    longint unsigned sq;
    longint unsigned rt;
    longint unsigned l24;
    c = code;
    if (c <= 10) return (c * 64'd6553600 + 64'd164730) / 64'd329460;
    t = (((64'd1000 * c + 64'd14025) << 25) + 64'd269025) / 64'd538050;
    sq = (t * t + (64'd1 << 23)) >> 24;
    rt = root_search(sq, 1'b1);
    l24 = (sq * rt + (64'd1 << 23)) >> 24;
    return (l24 + 64'd128) >> 8;
  endfunction

  function automatic logic [LW-1:0] predict_lstar(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
    longint unsigned y;
    longint unsigned u;
    longint unsigned res;
    longint signed v;
    y = (64'd2126 * srgb_to_linear(r) + 64'd7152 * srgb_to_linear(g)
         + 64'd722 * srgb_to_linear(b) + 64'd5000) / 64'd10000;
    if (y * 64'd24389 <= 64'd216 * 64'd65536) begin
      res = ((y * 64'd9033 << FRAC) + 64'd327680) / 64'd655360;
    end else begin
      u = root_search(y << 8, 1'b0);
      v = longint'(64'd116 * u) - longint'(64'd16 << 24);
      if (v <= 0) res = 0;
      else res = (longint'(v) + (64'd1 << (23 - FRAC))) >> (24 - FRAC);
    end
    if (res > (64'd100 << FRAC)) res = 64'd100 << FRAC;
    return LW'(res);
  endfunction

  task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit known,
                         logic [LW-1:0] l);
    pixel_row_t row;
    row.r = r; row.g = g; row.b = b; row.known = known; row.l = l;
    rows.push_back(row);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 34) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    lstar_q.push_back(predict_lstar(r, g, b));
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    n_sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (lstar_q.size() == 0) begin
        $display("%0t: unexpected item, actual %0d", $time, lightness);
        errors++;
      end else begin
        if (lightness !== lstar_q[0]) begin
          $display("%0t: lightness expected %0d actual %0d", $time, lstar_q[0],
                   lightness);
          errors++;
        end
        if (lstar_q[0] == (100 << FRAC)) n_sat++;
        if (lstar_q[0] < (8 << FRAC)) n_low++;
        void'(lstar_q.pop_front());
      end
      n_got++;
    end
  end

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else if (hold_off) result_ready <= 1'b0;
    else if (no_idle) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(99) >= 34);
  end

  initial begin
    wait (n_sent == 300);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int sel;
    add_row(8'd0, 8'd0, 8'd0, 1'b1, '0);
    add_row(8'd255, 8'd255, 8'd255, 1'b1, LW'(100 << FRAC));
    add_row(8'd255, 8'd0, 8'd0, 1'b0, '0);
    add_row(8'd0, 8'd255, 8'd0, 1'b0, '0);
    add_row(8'd0, 8'd0, 8'd255, 1'b0, '0);
    add_row(8'd10, 8'd10, 8'd10, 1'b0, '0);
    add_row(8'd11, 8'd11, 8'd11, 1'b0, '0);
    add_row(8'd1, 8'd0, 8'd0, 1'b0, '0);
    add_row(8'd0, 8'd1, 8'd0, 1'b0, '0);
    add_row(8'd0, 8'd0, 8'd1, 1'b0, '0);
    add_row(8'd24, 8'd24, 8'd24, 1'b0, '0);
    add_row(8'd25, 8'd25, 8'd25, 1'b0, '0);
    add_row(8'd0, 8'd40, 8'd0, 1'b0, '0);
    add_row(8'd170, 8'd85, 8'd170, 1'b0, '0);
    add_row(8'd85, 8'd170, 8'd85, 1'b0, '0);
    add_row(8'd254, 8'd254, 8'd254, 1'b0, '0);
    add_row(8'd128, 8'd128, 8'd128, 1'b0, '0);
    add_row(8'd255, 8'd255, 8'd0, 1'b0, '0);
    add_row(8'd0, 8'd255, 8'd255, 1'b0, '0);
    add_row(8'd255, 8'd0, 8'd255, 1'b0, '0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].known && predict_lstar(rows[i].r, rows[i].g, rows[i].b) !== rows[i].l) begin
        $display("%0t: table row %0d expected %0d actual %0d", $time, i, rows[i].l,
                 predict_lstar(rows[i].r, rows[i].g, rows[i].b));
        errors++;
      end
      send_pixel(rows[i].r, rows[i].g, rows[i].b);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 800);
      sel = $urandom_range(9);
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      if (sel == 0) begin
        r = 8'($urandom_range(12)); g = 8'($urandom_range(12));
        b = 8'($urandom_range(12));
      end else if (sel == 1) begin
        r = 8'($urandom_range(40)); g = r; b = r;
      end else if (sel == 2) begin
        r = 8'($urandom_range(255, 240)); g = 8'($urandom_range(255, 240));
        b = 8'($urandom_range(255, 240));
      end
      send_pixel(r, g, b);
    end
    pixel_valid <= 1'b0;
    no_idle = 1'b0;
    while (lstar_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("%0d pixels sent, %0d results checked (%0d dark, %0d saturated)",
             n_sent, n_got, n_low, n_sat);
    $display("directed extremes, both sRGB curve branches, long output stall");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
